FILE: rtl/idq_pkg.sv
package idq_pkg;

  // Storage geometry. The ring arithmetic relies on DEPTH being a power of two.
  localparam int DEPTH   = 1024;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = PTR_W + 1;
  localparam int VALUE_W = 64;
  localparam int OP_W    = 3;
  localparam int ST_W    = 2;
  localparam int POS_W   = 10;

  // Packed stream widths, rounded up to whole bytes.
  localparam int IN_BITS  = OP_W + VALUE_W + POS_W;
  localparam int OUT_BITS = VALUE_W + ST_W + CNT_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // APB register map: one 64-bit register at byte address 0.
  localparam int ADDR_W  = 4;
  localparam int CFG_W   = 64;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd1;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ       = 3'd4;
  localparam logic [OP_W-1:0] OP_WRITE      = 3'd5;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd6;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic exec;
    logic load_out;
  } idq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;
  } idq_stat_t;

endpackage

FILE: rtl/indexed_double_ended_queue_top.sv
// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  s_tdata: opcode, write_value, position
// m_*       out        m_tvalid / m_tready  m_tdata: read_value, status, item_total
// APB       in         psel, penable, pwrite undef_value at byte address 0
//
// Each transaction passes through capture, execute on the slot memory, and
// load of the output register; the single synchronous memory port sets this.
// A new transaction is accepted while a finished result still waits in the output
// register. A stalled m_tready holds the next result back in the controller.
// Synchronous reset empties the queue and clears undef_value; slot contents are
// left as they are.
module indexed_double_ended_queue_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // s_tdata: opcode[2:0], write_value[66:3], position[76:67], zeros above
  input  logic [idq_pkg::IN_W-1:0]     s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // m_tdata: read_value[63:0], status[65:64], item_total[76:66], zeros above
  output logic [idq_pkg::OUT_W-1:0]    m_tdata,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [idq_pkg::ADDR_W-1:0]   paddr,
  input  logic [idq_pkg::CFG_W-1:0]    pwdata,
  output logic [idq_pkg::CFG_W-1:0]    prdata,
  output logic                         pready
);
  import idq_pkg::*;

  idq_cmd_t           cmd;
  idq_stat_t          stat;
  logic               cfg_we;
  logic [VALUE_W-1:0] undef_value;

  // Register decode: the register index is paddr divided by eight.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && !paddr[ADDR_W-1];
  assign prdata = paddr[ADDR_W-1] ? '0 : CFG_W'(undef_value);

  idq_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  idq_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_we      (cfg_we),
    .cfg_wdata   (pwdata),
    .undef_value (undef_value)
  );

endmodule

FILE: rtl/idq_datapath.sv
module idq_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  idq_pkg::idq_cmd_t            cmd,
  output idq_pkg::idq_stat_t           stat,
  // s_tdata: opcode, write_value, position (from bit 0 up), zero padded
  input  logic [idq_pkg::IN_W-1:0]     s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // m_tdata: read_value, status, item_total (from bit 0 up), zero padded
  output logic [idq_pkg::OUT_W-1:0]    m_tdata,
  input  logic                         cfg_we,
  input  logic [idq_pkg::CFG_W-1:0]    cfg_wdata,
  output logic [idq_pkg::VALUE_W-1:0]  undef_value
);
  import idq_pkg::*;

  // Sources for the result value.
  localparam logic [1:0] SRC_ZERO  = 2'd0;
  localparam logic [1:0] SRC_UNDEF = 2'd1;
  localparam logic [1:0] SRC_MEM   = 2'd2;

  logic [VALUE_W-1:0] slot_store [DEPTH];

  logic [OP_W-1:0]    in_opcode;
  logic [VALUE_W-1:0] in_value;
  logic [POS_W-1:0]   in_position;

  logic [PTR_W-1:0]   front_pointer, front_pointer_next;
  logic [CNT_W-1:0]   element_count, element_count_next;

  logic [ST_W-1:0]    pend_status, pend_status_next;
  logic [1:0]         pend_src, pend_src_next;
  logic [VALUE_W-1:0] mem_rdata;

  logic               mem_we, mem_re;
  logic [PTR_W-1:0]   mem_addr;

  logic [VALUE_W-1:0] out_value;
  logic [ST_W-1:0]    out_status;
  logic [CNT_W-1:0]   out_total;
  logic               out_valid;

  logic               is_full, is_empty, in_range;
  logic [PTR_W-1:0]   count_low;

  assign stat.out_busy = out_valid && !m_tready;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      undef_value <= '0;
    end else if (cfg_we) begin
      undef_value <= cfg_wdata[VALUE_W-1:0];
    end
  end

  // Input capture.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_opcode   <= s_tdata[OP_W-1:0];
      in_value    <= s_tdata[OP_W+VALUE_W-1:OP_W];
      in_position <= s_tdata[OP_W+VALUE_W+POS_W-1:OP_W+VALUE_W];
    end
  end

  assign is_full   = element_count[PTR_W];
  assign is_empty  = (element_count == '0);
  assign in_range  = ({1'b0, in_position} < element_count);
  assign count_low = element_count[PTR_W-1:0];

  // Operation decode: slot address, memory access and pointer updates.
  always_comb begin
    front_pointer_next = front_pointer;
    element_count_next = element_count;
    pend_status_next   = ST_OK;
    pend_src_next      = SRC_ZERO;
    mem_we             = 1'b0;
    mem_re             = 1'b0;
    mem_addr           = front_pointer;
    case (in_opcode)
      OP_PUSH_BACK: begin
        mem_addr = PTR_W'(front_pointer + count_low);
        if (is_full) begin
          pend_status_next = ST_FULL;
        end else begin
          mem_we             = cmd.exec;
          element_count_next = element_count + CNT_W'(1);
        end
      end
      OP_POP_BACK: begin
        mem_addr = PTR_W'(front_pointer + count_low - PTR_W'(1));
        if (is_empty) begin
          pend_status_next = ST_EMPTY;
          pend_src_next    = SRC_UNDEF;
        end else begin
          mem_re             = cmd.exec;
          pend_src_next      = SRC_MEM;
          element_count_next = element_count - CNT_W'(1);
        end
      end
      OP_PUSH_FRONT: begin
        mem_addr = PTR_W'(front_pointer - PTR_W'(1));
        if (is_full) begin
          pend_status_next = ST_FULL;
        end else begin
          mem_we             = cmd.exec;
          front_pointer_next = mem_addr;
          element_count_next = element_count + CNT_W'(1);
        end
      end
      OP_POP_FRONT: begin
        mem_addr = front_pointer;
        if (is_empty) begin
          pend_status_next = ST_EMPTY;
          pend_src_next    = SRC_UNDEF;
        end else begin
          mem_re             = cmd.exec;
          pend_src_next      = SRC_MEM;
          front_pointer_next = PTR_W'(front_pointer + PTR_W'(1));
          element_count_next = element_count - CNT_W'(1);
        end
      end
      OP_READ: begin
        mem_addr = PTR_W'(front_pointer + PTR_W'(in_position));
        if (!in_range) begin
          pend_status_next = ST_EMPTY;
          pend_src_next    = SRC_UNDEF;
        end else begin
          mem_re        = cmd.exec;
          pend_src_next = SRC_MEM;
        end
      end
      OP_WRITE: begin
        mem_addr = PTR_W'(front_pointer + PTR_W'(in_position));
        if (!in_range) begin
          pend_status_next = ST_EMPTY;
          pend_src_next    = SRC_UNDEF;
        end else begin
          mem_we = cmd.exec;
        end
      end
      OP_CLEAR: begin
        front_pointer_next = '0;
        element_count_next = '0;
      end
      default: begin
      end
    endcase
  end

  // Ring state and pending result.
  always_ff @(posedge clk) begin
    if (rst) begin
      front_pointer <= '0;
      element_count <= '0;
    end else if (cmd.exec) begin
      front_pointer <= front_pointer_next;
      element_count <= element_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      pend_status <= pend_status_next;
      pend_src    <= pend_src_next;
    end
  end

  // Slot memory with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_store[mem_addr] <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_rdata <= slot_store[mem_addr];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status <= pend_status;
      out_total  <= element_count;
      case (pend_src)
        SRC_UNDEF: out_value <= undef_value;
        SRC_MEM:   out_value <= mem_rdata;
        default:   out_value <= '0;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(OUT_W - OUT_BITS)'(0), out_total, out_status, out_value};

endmodule

FILE: rtl/idq_controller.sv
module idq_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  idq_pkg::idq_stat_t stat,
  output idq_pkg::idq_cmd_t  cmd
);
  import idq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state, state_next;

  // Next state and command decode.
  always_comb begin
    state_next   = state;
    s_tready     = 1'b0;
    cmd.load_in  = 1'b0;
    cmd.exec     = 1'b0;
    cmd.load_out = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready    = 1'b1;
        cmd.load_in = s_tvalid;
        if (s_tvalid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        // Wait here until the output register can take the result.
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/idq_checker.sv
module idq_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [idq_pkg::OUT_W-1:0] m_tdata
);
  import idq_pkg::*;

  // No result is offered straight after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered after reset");

  // A stalled result keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // The count reported never exceeds the capacity.
  a_total: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[VALUE_W+ST_W+CNT_W-1:VALUE_W+ST_W] <= CNT_W'(DEPTH))
    else $error("item total beyond capacity");

  // Status is never the unused code.
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[VALUE_W+ST_W-1:VALUE_W] != 2'd3)
    else $error("unused status code");

  // One transaction is worked on at a time: no accept in the cycle after one.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("accepted back to back");

endmodule

bind indexed_double_ended_queue_top idq_checker u_idq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
